### sv/double_window_burst_gate_macros.svh
`ifndef DOUBLE_WINDOW_BURST_GATE_MACROS_SVH
`define DOUBLE_WINDOW_BURST_GATE_MACROS_SVH

// condition that must hold at every edge outside reset
`define DWBG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication outside reset
`define DWBG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### sv/dwbg_pkg.sv
package dwbg_pkg;

  // decoupling queue between trigger front and gate back
  localparam int QDEPTH    = 8;
  localparam int QCW       = $clog2(QDEPTH + 1);
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int WIN_REG_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE     = 2'd0,
    REG_RATIO_THRESHOLD = 2'd1,
    REG_BURST_LENGTH    = 2'd2,
    REG_END_HOLDOFF     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] ratio_threshold;
    logic [REG_W-1:0] burst_length;
    logic [REG_W-1:0] end_holdoff;
  } cfg_regs_t;

  typedef struct packed {
    logic start_hit;
    logic end_hit;
  } trig_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } fifo_stat_t;

endpackage

### sv/dwbg_ram.sv
module dwbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/dwbg_front.sv
module dwbg_front import dwbg_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     win,
  input  logic [REG_W-1:0]                    ratio,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_q,
  input  fifo_stat_t                          fstat,
  output logic                                push,
  output trig_t                               push_trig,
  output logic [2*SAMPLE_BITS-1:0]            push_x,
  output logic [1:0]                          inflight
);

  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = 2 * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * SAMPLE_BITS;
  localparam int SUMW  = PW + $clog2(MAX_WINDOW);
  localparam int PRW   = SUMW + REG_W;

  function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] pos,
                                               input logic [AW:0] k);
    logic [AW+1:0] t;
    t = {2'b00, pos} + (AW+2)'(DEPTH) - {1'b0, k};
    if (t >= (AW+2)'(DEPTH)) begin
      t = t - (AW+2)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  logic                 accept;
  logic [QCW:0]         occ;
  logic signed [PW-1:0] sq_i, sq_q;
  logic [PW-1:0]        power;
  logic [AW:0]          k1, k2;
  logic [AW-1:0]        wr_pos, wr_pos_next;
  logic [WW:0]          fill_count;
  logic                 filling, second_half;

  logic                 v0, v1, v2;
  logic [PW-1:0]        p0;
  logic                 fill0, second0;
  logic [PW-1:0]        pmid_rd, pold_rd, x_rd;
  logic [PW-1:0]        pm, po;
  logic [SUMW-1:0]      newer_sum, older_sum, newer_next, older_next;

  logic                 oper1, oper2;
  logic [PW-1:0]        x1, x2;
  logic [PRW-1:0]       n256, o256, r_older, r_newer;

  assign inflight = {1'b0, v0} + {1'b0, v1} + {1'b0, v2};
  assign occ      = (QCW+1)'(fstat.count) + (QCW+1)'(inflight);
  assign in_ready = occ < (QCW+1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  // squares of signed values are the squares of the magnitudes
  assign sq_i  = in_i * in_i;
  assign sq_q  = in_q * in_q;
  assign power = $unsigned(sq_i) + $unsigned(sq_q);

  assign k1          = (AW+1)'(win);
  assign k2          = (AW+1)'({win, 1'b0});
  assign filling     = fill_count < {win, 1'b0};
  assign second_half = fill_count >= {1'b0, win};
  assign wr_pos_next = (wr_pos == AW'(DEPTH - 1)) ? '0 : wr_pos + AW'(1);

  dwbg_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pmid_ram (
    .clk(clk), .we(accept), .waddr(wr_pos), .wdata(power),
    .re(accept), .raddr(back_slot(wr_pos, k1)), .rdata(pmid_rd)
  );

  dwbg_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pold_ram (
    .clk(clk), .we(accept), .waddr(wr_pos), .wdata(power),
    .re(accept), .raddr(back_slot(wr_pos, k2)), .rdata(pold_rd)
  );

  dwbg_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_sample_ram (
    .clk(clk), .we(accept), .waddr(wr_pos), .wdata({in_q, in_i}),
    .re(accept), .raddr(back_slot(wr_pos, k2)), .rdata(x_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
    end else if (accept) begin
      wr_pos <= wr_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      fill_count <= '0;
    end else if (accept && filling) begin
      fill_count <= fill_count + (WW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0      <= power;
      fill0   <= filling;
      second0 <= second_half;
    end
  end

  // window sums: mid tap moves from newer to older, oldest tap leaves
  assign pm         = (second0 || !fill0) ? pmid_rd : '0;
  assign po         = !fill0 ? pold_rd : '0;
  assign newer_next = newer_sum + SUMW'(p0) - SUMW'(pm);
  assign older_next = older_sum + SUMW'(pm) - SUMW'(po);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      newer_sum <= '0;
      older_sum <= '0;
    end else if (v0) begin
      newer_sum <= newer_next;
      older_sum <= older_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v0) begin
      oper1 <= !fill0;
      x1    <= x_rd;
    end
  end

  // cross products of the threshold test
  always_ff @(posedge clk) begin
    if (v1) begin
      oper2   <= oper1;
      x2      <= x1;
      n256    <= PRW'({newer_sum, 8'b0});
      o256    <= PRW'({older_sum, 8'b0});
      r_older <= ratio * older_sum;
      r_newer <= ratio * newer_sum;
    end
  end

  assign push                = v2 && oper2;
  assign push_trig.start_hit = n256 > r_older;
  assign push_trig.end_hit   = o256 > r_newer;
  assign push_x              = x2;

endmodule

### sv/dwbg_fifo.sv
module dwbg_fifo import dwbg_pkg::*; #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fifo_stat_t       stat
);

  localparam int QAW = $clog2(QDEPTH);

  logic [WIDTH-1:0] slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QCW-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata      = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

endmodule

### sv/dwbg_back.sv
module dwbg_back import dwbg_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  cfg_regs_t                       cfg,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] win,
  input  fifo_stat_t                      fstat,
  input  trig_t                           head_trig,
  input  logic [2*SAMPLE_BITS-1:0]        head_x,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   out_i,
  output logic signed [SAMPLE_BITS-1:0]   out_q,
  output logic                            out_start,
  output logic                            out_last
);

  logic [REG_W-1:0]        pc, pc_a, pc_b, pc_next, two_w;
  logic signed [REG_W+1:0] lim, pc_s;
  logic                    hold_ok, emit;

  assign two_w = REG_W'({win, 1'b0});
  assign pop   = !fstat.empty && (!out_valid || out_ready);

  always_comb begin
    pc_a    = (head_trig.start_hit && pc == '0) ? cfg.burst_length : pc;
    lim     = $signed({2'b00, cfg.burst_length}) - $signed({2'b00, cfg.end_holdoff});
    pc_s    = $signed({2'b00, pc_a});
    hold_ok = pc_s < lim;
    pc_b    = (head_trig.end_hit && pc_a != '0 && hold_ok) ? two_w : pc_a;
    emit    = pc_b != '0;
    pc_next = emit ? pc_b - REG_W'(1) : pc_b;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pc <= '0;
    end else if (pop) begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_i     <= head_x[SAMPLE_BITS-1:0];
      out_q     <= head_x[2*SAMPLE_BITS-1:SAMPLE_BITS];
      out_start <= pc_b == cfg.burst_length;
      out_last  <= pc_b == REG_W'(1);
    end
  end

endmodule

### sv/double_window_burst_gate.sv
// double sliding window burst gate
//
// input stream: one complex sample per word (i low, q high); the power i*i+q*q
// feeds two adjacent running sums, newer and older, of window_size samples each.
// output stream: samples delayed by 2*window_size, passed only inside a burst,
// with tuser marking the first word of a burst and tlast the word that ends it.
// config port: cfg_we/cfg_index/cfg_data, written while the block is idle;
// writing window_size restarts the fill of both windows and drops any burst.
// throughput: one sample per clock while s_axis_tready is high. a passed sample
// goes through the delay lines (read on the accepting edge), then the sum
// update, the threshold products, the compare into the queue and the load of
// the output register.
// the first 2*window_size samples after reset or restart only fill the windows
// and give no output. reset clears sums, fill and burst counter; the delay
// lines are not cleared since no entry is used before it is written.
// when the receiver stalls the output register holds its word; the 8-entry
// queue behind the trigger pipeline absorbs what is in flight, and s_axis_tready
// drops once queue plus pipeline hold 8 words.
module double_window_burst_gate import dwbg_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration write
  input  logic                                    cfg_we,
  input  logic [CFG_IDX_W-1:0]                    cfg_index,
  input  logic [REG_W-1:0]                        cfg_data,
  // input samples
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sample_i, sample_q
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // gated samples
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // out_i, out_q
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // burst_start
  output logic                                    m_axis_tuser,
  // burst_last
  output logic                                    m_axis_tlast
);

  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam int TDW = ((2*SAMPLE_BITS + 7) / 8) * 8;
  localparam int XW  = 2 * SAMPLE_BITS;
  localparam int QW  = $bits(trig_t) + XW;

  // zero taken as one, oversize taken as the largest window
  function automatic logic [WW-1:0] clamp_window(input logic [WIN_REG_W-1:0] v);
    logic [WW-1:0] r;
    if (v == '0) begin
      r = WW'(1);
    end else if (int'(v) > MAX_WINDOW) begin
      r = WW'(MAX_WINDOW);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  cfg_regs_t                     cfg;
  logic [WW-1:0]                 win;
  logic                          restart;

  logic                          push, pop;
  trig_t                         push_trig, head_trig;
  logic [XW-1:0]                 push_x, head_x;
  logic [1:0]                    inflight;
  fifo_stat_t                    fstat;
  logic signed [SAMPLE_BITS-1:0] out_i, out_q;
  logic [QCW:0]                  occupancy;

  assign restart = cfg_we && (cfg_reg_t'(cfg_index) == REG_WINDOW_SIZE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win                 <= clamp_window(WIN_REG_W'(16));
      cfg.ratio_threshold <= REG_W'(1024);
      cfg.burst_length    <= REG_W'(240);
      cfg.end_holdoff     <= REG_W'(16);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_SIZE:     win                 <= clamp_window(cfg_data[WIN_REG_W-1:0]);
        REG_RATIO_THRESHOLD: cfg.ratio_threshold <= cfg_data;
        REG_BURST_LENGTH:    cfg.burst_length    <= cfg_data;
        REG_END_HOLDOFF:     cfg.end_holdoff     <= cfg_data;
        default:             win                 <= win;
      endcase
    end
  end

  // front: delay lines, window sums, threshold tests
  dwbg_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .win       (win),
    .ratio     (cfg.ratio_threshold),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_i      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_q      (s_axis_tdata[XW-1:SAMPLE_BITS]),
    .fstat     (fstat),
    .push      (push),
    .push_trig (push_trig),
    .push_x    (push_x),
    .inflight  (inflight)
  );

  dwbg_fifo #(.WIDTH(QW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_trig, push_x}),
    .pop   (pop),
    .rdata ({head_trig, head_x}),
    .stat  (fstat)
  );

  // back: burst counter and output register
  dwbg_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .cfg       (cfg),
    .win       (win),
    .fstat     (fstat),
    .head_trig (head_trig),
    .head_x    (head_x),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_i     (out_i),
    .out_q     (out_q),
    .out_start (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = TDW'({out_q, out_i});

  // words held in the queue plus words still in the trigger pipeline
  assign occupancy = (QCW+1)'(fstat.count) + (QCW+1)'(inflight);

  `include "double_window_burst_gate_macros.svh"

  `DWBG_ASSERT_ALWAYS(a_queue_bound, fstat.count <= QCW'(QDEPTH), "queue count beyond depth")
  `DWBG_ASSERT_IMPLY(a_pop_nonempty, pop, !fstat.empty, "pop from empty queue")
  `DWBG_ASSERT_ALWAYS(a_credit, occupancy <= (QCW+1)'(QDEPTH), "queue plus pipeline too full")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dwbg_pkg::*;

  localparam int STORE_DEPTH = 128;   // two windows of the largest size
  localparam int DRAIN_CYCLES = 16;   // pipeline plus output queue
  localparam int STALL_LIMIT = 4000;  // cycles with no word moving

  // one gated word as it should leave the block
  typedef struct {
    logic [15:0] i_part;
    logic [15:0] q_part;
    logic        is_start;
    logic        is_last;
  } gated_word_t;

  // amplitude classes for the random sample segments
  typedef enum int {
    AMP_ZERO,
    AMP_TINY,
    AMP_LOW,
    AMP_MID,
    AMP_FULL,
    AMP_RAIL
  } amp_t;

  class burst_scoreboard;
    // register copies
    bit [6:0]  win_reg;
    bit [15:0] ratio;
    bit [15:0] blen;
    bit [15:0] holdoff;
    // gate state
    bit [31:0] sample_mem [STORE_DEPTH];
    bit [31:0] power_mem [STORE_DEPTH];
    longint unsigned newer;
    longint unsigned older;
    bit [15:0] pass_cnt;
    int unsigned fill;
    int unsigned wr;
    gated_word_t gated_due [$];
    int errors;

    function new();
      win_reg = 7'd16;
      ratio = 16'd1024;
      blen = 16'd240;
      holdoff = 16'd16;
      wr = 0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      newer = 0;
      older = 0;
      fill = 0;
      pass_cnt = '0;
    endfunction

    // window register 0 counts as 1, anything above 64 as 64
    function longint unsigned span();
      if (win_reg == 0) return 1;
      if (win_reg > 64) return 64;
      return win_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_WINDOW_SIZE: begin
          win_reg = val[6:0];
          restart();
        end
        REG_RATIO_THRESHOLD: ratio = val;
        REG_BURST_LENGTH:    blen = val;
        REG_END_HOLDOFF:     holdoff = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [31:0] word);
      logic signed [15:0] si;
      logic signed [15:0] sq;
      longint unsigned w;
      longint unsigned p;
      longint unsigned pmid;
      longint unsigned pold;
      bit [31:0] xold;
      int unsigned slot_mid;
      int unsigned slot_old;
      gated_word_t g;
      si = word[15:0];
      sq = word[31:16];
      w = span();
      p = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
      slot_mid = (wr + STORE_DEPTH - w) % STORE_DEPTH;
      slot_old = (wr + STORE_DEPTH - 2 * w) % STORE_DEPTH;
      pmid = power_mem[slot_mid];
      pold = power_mem[slot_old];
      xold = sample_mem[slot_old];
      if (fill < 2 * w) begin
        // still filling both windows, nothing leaves
        newer += p;
        if (fill >= w) begin
          newer -= pmid;
          older += pmid;
        end
        fill++;
      end else begin
        newer = newer + p - pmid;
        older = older + pmid - pold;
        // ratio tests by cross-multiplication, threshold has 8 fraction bits
        if (newer * 256 > ratio * older && pass_cnt == 0)
          pass_cnt = blen;
        if (older * 256 > ratio * newer && pass_cnt > 0 &&
            longint'(pass_cnt) < longint'(blen) - longint'(holdoff))
          pass_cnt = 2 * w;
        if (pass_cnt > 0) begin
          g.i_part = xold[15:0];
          g.q_part = xold[31:16];
          g.is_start = (pass_cnt == blen);
          pass_cnt--;
          g.is_last = (pass_cnt == 0);
          gated_due.push_back(g);
        end
      end
      sample_mem[wr] = word;
      power_mem[wr] = p[31:0];
      wr = (wr + 1) % STORE_DEPTH;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [31:0] data, logic user, logic last);
      gated_word_t g;
      if (gated_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h start %b last %b", data, user, last));
        return;
      end
      g = gated_due.pop_front();
      if (data[15:0] !== g.i_part)
        report_mismatch($sformatf("out_i %h, want %h", data[15:0], g.i_part));
      if (data[31:16] !== g.q_part)
        report_mismatch($sformatf("out_q %h, want %h", data[31:16], g.q_part));
      if (user !== g.is_start)
        report_mismatch($sformatf("burst_start %b, want %b", user, g.is_start));
      if (last !== g.is_last)
        report_mismatch($sformatf("burst_last %b, want %b", last, g.is_last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // sample_i, sample_q
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // out_i, out_q
  logic m_axis_tuser;               // burst_start
  logic m_axis_tlast;               // burst_last

  burst_scoreboard sb = new();
  bit no_idle = 1'b0;               // stretches with both sides running flat out
  int unsigned quiet_cycles = 0;

  double_window_burst_gate u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_part(amp_t lvl);
    int v;
    case (lvl)
      AMP_ZERO: v = 0;
      AMP_TINY: v = $urandom_range(0, 6) - 3;
      AMP_LOW:  v = $urandom_range(0, 511) - 256;
      AMP_MID:  v = $urandom_range(0, 8191) - 4096;
      AMP_FULL: v = $urandom();
      default: begin
        case ($urandom_range(0, 2))
          0: v = 32'h8000;
          1: v = 32'h7fff;
          default: v = 32'h8001;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  function automatic amp_t pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return AMP_ZERO;
    if (r < 30) return AMP_TINY;
    if (r < 45) return AMP_LOW;
    if (r < 60) return AMP_MID;
    if (r < 90) return AMP_FULL;
    return AMP_RAIL;
  endfunction

  // input side: hold the word until the block takes it
  task automatic send_sample(input logic [15:0] si, input logic [15:0] sq);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sq, si};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // single register write; caller drops cfg_we afterwards
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [15:0] win, input logic [15:0] thr,
                           input logic [15:0] blen, input logic [15:0] hold);
    write_reg(REG_WINDOW_SIZE, win);
    write_reg(REG_RATIO_THRESHOLD, thr);
    write_reg(REG_BURST_LENGTH, blen);
    write_reg(REG_END_HOLDOFF, hold);
    cfg_we <= 1'b0;
  endtask

  // stop sending, let every expected word out, then let the pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.gated_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // segments of one amplitude class so the two windows see real contrast,
  // with an occasional segment of mixed noise
  task automatic run_phase(input logic [15:0] win, input logic [15:0] thr,
                           input logic [15:0] blen, input logic [15:0] hold,
                           input int unsigned n_items, input bit calm);
    int unsigned left;
    int unsigned seg;
    int unsigned w;
    bit mixed;
    amp_t lvl;
    wait_idle();
    configure(win, thr, blen, hold);
    no_idle = calm;
    w = sb.span();
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(1, 3 * w + 2);
      if (seg > left) seg = left;
      mixed = ($urandom_range(0, 7) == 0);
      lvl = pick_level();
      repeat (seg) begin
        if (mixed) lvl = pick_level();
        send_sample(rand_part(lvl), rand_part(lvl));
      end
      left -= seg;
    end
    no_idle = 1'b0;
  endtask

  // receiver side stalls
  initial begin
    int unsigned stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // accepted words on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAIL double_window_burst_gate");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: one-sample windows, other registers at reset values;
    // all-zero windows first, then rail values and alternating bit patterns
    write_reg(REG_WINDOW_SIZE, 16'd1);
    cfg_we <= 1'b0;
    repeat (4) send_sample(16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h8000, 16'h0000);
    send_sample(16'h0001, 16'hffff);
    send_sample(16'hffff, 16'hffff);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h5555, 16'haaaa);
    send_sample(16'haaaa, 16'h5555);
    send_sample(16'h0000, 16'h0001);
    send_sample(16'h8001, 16'h7ffe);
    send_sample(16'h0000, 16'h0000);

    // random phases across register settings
    run_phase(16'd16, 16'd1024, 16'd240, 16'd16, 80, 1'b0);
    // upper data bits set on the window write, largest window and ratio
    run_phase(16'hff40, 16'hffff, 16'hffff, 16'd0, 200, 1'b0);
    // window zero acts as one, zero threshold, holdoff past burst length
    run_phase(16'd0, 16'd0, 16'd1, 16'hffff, 80, 1'b1);
    run_phase(16'd2, 16'd256, 16'd8, 16'd2, 80, 1'b0);
    // zero burst length passes nothing
    run_phase(16'd3, 16'd300, 16'd0, 16'd0, 40, 1'b0);
    run_phase(16'd5, 16'd384, 16'd20, 16'd5, 100, 1'b1);
    // window above the maximum clamps to it
    run_phase(16'd100, 16'd2048, 16'd300, 16'd100, 200, 1'b0);
    run_phase(16'd1, 16'hffff, 16'd4, 16'd1, 60, 1'b0);

    wait_idle();
    if (sb.errors == 0)
      $display("PASS double_window_burst_gate");
    else
      $display("FAIL double_window_burst_gate");
    $finish;
  end

endmodule
